FILE: rtl/lpsb_pkg.sv
// Shared types, codes and constants of the link poll scheduler.
// Used by the channel interfaces, the controller, the datapath and the checker.
package lpsb_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   localparam int MS_PER_S   = 1000;
   localparam int FAIL_MAX   = 8;
   localparam int SHIFT_MAX  = 4;
   localparam int PROD_W     = 26;
   localparam int IV_W       = PROD_W + SHIFT_MAX;

   localparam logic [31:0] CONNECT_TIMEOUT_RESET = 32'd15000;
   localparam logic [31:0] RETRY_INTERVAL_RESET  = 32'd30000;
   localparam logic [31:0] MAX_BACKOFF_RESET     = 32'd900000;
   localparam logic [3:0]  ACTIVE_SLOTS_RESET    = 4'd8;

   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_POLL  = 3'd2;
   localparam logic [2:0] KIND_STOP  = 3'd3;
   localparam logic [2:0] KIND_SETUP = 3'd4;

   localparam logic [1:0] REG_CONNECT_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_RETRY_INTERVAL  = 2'd1;
   localparam logic [1:0] REG_MAX_BACKOFF     = 2'd2;
   localparam logic [1:0] REG_ACTIVE_SLOTS    = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_CONNECTING = 2'd1,
      PH_CONNECTED  = 2'd2,
      PH_FAILED     = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_INIT       = 3'd0,
      ST_CONNECTING = 3'd1,
      ST_CONNECTED  = 3'd2,
      ST_LINK_FAIL  = 3'd3,
      ST_NO_CREDS   = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] now_ms;
      logic        link_up;
      logic        has_credentials;
      logic        poll_ok;
      logic [2:0]  slot;
      logic        slot_enabled;
      logic        slot_configured;
      logic        slot_auth_needed;
      logic [15:0] slot_base_seconds;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  link_state;
      logic [2:0]  status;
      logic [15:0] connect_failures;
      logic        connect_request;
      logic        disconnect_request;
      logic        dispatch_valid;
      logic [2:0]  dispatch_slot;
      logic [31:0] next_delay_ms;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [31:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic idx_step;
      logic clear_slot;
      logic scan_check;
      logic pd_fail;
      logic pd_cap;
      logic pd_next;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic need_clear;
      logic need_scan;
      logic need_poll;
      logic idx_last;
      logic slot_due;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/lpsb_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on lpsb_pkg for the payload types.
interface lpsb_req_if;
   import lpsb_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lpsb_rsp_if;
   import lpsb_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lpsb_csr_if;
   import lpsb_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/lpsb_controller.sv
// Sequencing state machine of the link poll scheduler.
// Depends on lpsb_pkg; drives the datapath through command and status structs.
module lpsb_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lpsb_pkg::stat_type stat,
   output lpsb_pkg::cmd_type  cmd
);
   import lpsb_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_EXEC    = 8'b0000_0010,
      S_CLEAR   = 8'b0000_0100,
      S_SCAN    = 8'b0000_1000,
      S_PD_FAIL = 8'b0001_0000,
      S_PD_CAP  = 8'b0010_0000,
      S_PD_NEXT = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } ctl_state_type;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.need_clear) begin
               state_in = S_CLEAR;
            end else if (stat.need_scan) begin
               state_in = S_SCAN;
            end else if (stat.need_poll) begin
               state_in = S_PD_FAIL;
            end else begin
               state_in = S_RESP;
            end
         end
         S_CLEAR: begin
            cmd.clear_slot = 1'b1;
            cmd.idx_step   = 1'b1;
            if (stat.idx_last) begin
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            cmd.scan_check = 1'b1;
            cmd.idx_step   = 1'b1;
            if (stat.slot_due || stat.idx_last) begin
               state_in = S_RESP;
            end
         end
         S_PD_FAIL: begin
            cmd.pd_fail = 1'b1;
            state_in    = S_PD_CAP;
         end
         S_PD_CAP: begin
            cmd.pd_cap = 1'b1;
            state_in   = S_PD_NEXT;
         end
         S_PD_NEXT: begin
            cmd.pd_next = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/lpsb_datapath.sv
// Link state, configuration registers, slot table, backoff arithmetic and result register.
// Depends on lpsb_pkg; steered by lpsb_controller through command and status structs.
module lpsb_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  lpsb_pkg::cmd_type         cmd,
   output lpsb_pkg::stat_type        stat,
   input  lpsb_pkg::req_payload_type req_item,
   input  logic                      csr_valid,
   input  lpsb_pkg::csr_payload_type csr_item,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lpsb_pkg::rsp_payload_type rsp_item
);
   import lpsb_pkg::*;

   req_payload_type item_ff, item_in;
   logic [31:0]     timeout_ff, retry_ff, max_ff;
   logic [3:0]      nslots_ff;
   phase_type       phase_ff, phase_in;
   logic [31:0]     start_ff, start_in;
   status_type      status_ff, status_in;
   logic [15:0]     cfail_ff, cfail_in;
   logic            busy_ff, busy_in;
   logic            stopped_ff, stopped_in;
   logic [SLOT_W-1:0] active_ff, active_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic            creq_ff, creq_in, dreq_ff, dreq_in, dval_ff, dval_in;
   logic [SLOT_W-1:0] dslot_ff, dslot_in;
   logic [31:0]     delay_ff, delay_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [2:0]      shift_ff, shift_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_item_ff, rsp_item_in;

   logic [2:0]  flags_ff [SLOT_COUNT];
   logic [15:0] base_ff  [SLOT_COUNT];
   logic [3:0]  fail_ff  [SLOT_COUNT];
   logic [31:0] next_ff  [SLOT_COUNT];

   logic [CNT_W-1:0]  lim;
   logic              lim_zero;
   logic [SLOT_W-1:0] idx;
   logic [SLOT_W-1:0] setup_idx;
   logic              setup_hit;
   logic [31:0]       elapsed;
   logic              due;
   logic [3:0]        fail_cur;
   logic [3:0]        fail_new;
   logic [IV_W-1:0]   iv;
   logic [31:0]       iv_ext;

   assign lim       = (32'(nslots_ff) < SLOT_COUNT) ? CNT_W'(nslots_ff) : CNT_W'(SLOT_COUNT);
   assign lim_zero  = (lim == '0);
   assign idx       = idx_ff[SLOT_W-1:0];
   assign setup_idx = SLOT_W'(item_ff.slot);
   assign setup_hit = (32'(item_ff.slot) < SLOT_COUNT);
   assign elapsed   = item_ff.now_ms - start_ff;
   assign due       = flags_ff[idx][0] && flags_ff[idx][1] && !flags_ff[idx][2] &&
                      ((next_ff[idx] == 32'd0) || (item_ff.now_ms >= next_ff[idx]));

   assign fail_cur = fail_ff[active_ff];
   always_comb begin
      if (item_ff.poll_ok) begin
         fail_new = 4'd0;
      end else if (32'(fail_cur) < FAIL_MAX) begin
         fail_new = fail_cur + 4'd1;
      end else begin
         fail_new = fail_cur;
      end
   end

   assign iv     = IV_W'(prod_ff) << shift_ff;
   assign iv_ext = 32'(iv);

   assign stat.need_clear = (item_ff.kind == KIND_TICK) && (phase_ff == PH_CONNECTING) &&
                            item_ff.link_up && !lim_zero;
   assign stat.need_scan  = (item_ff.kind == KIND_TICK) && (phase_ff == PH_CONNECTED) &&
                            item_ff.link_up && !busy_ff && !stopped_ff && !lim_zero;
   assign stat.need_poll  = (item_ff.kind == KIND_POLL) && busy_ff;
   assign stat.idx_last   = ({1'b0, idx_ff} + 1'b1) >= {1'b0, lim};
   assign stat.slot_due   = due;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      item_in      = item_ff;
      phase_in     = phase_ff;
      start_in     = start_ff;
      status_in    = status_ff;
      cfail_in     = cfail_ff;
      busy_in      = busy_ff;
      stopped_in   = stopped_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      creq_in      = creq_ff;
      dreq_in      = dreq_ff;
      dval_in      = dval_ff;
      dslot_in     = dslot_ff;
      delay_in     = delay_ff;
      prod_in      = prod_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;

      if (cmd.load_item) begin
         item_in  = req_item;
         idx_in   = '0;
         creq_in  = 1'b0;
         dreq_in  = 1'b0;
         dval_in  = 1'b0;
         dslot_in = '0;
         delay_in = 32'd0;
      end
      if (cmd.idx_step) begin
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.exec) begin
         case (item_ff.kind)
            KIND_TICK: begin
               case (phase_ff)
                  PH_CONNECTING: begin
                     if (item_ff.link_up) begin
                        phase_in  = PH_CONNECTED;
                        status_in = ST_CONNECTED;
                        cfail_in  = 16'd0;
                     end else if (elapsed >= timeout_ff) begin
                        dreq_in   = 1'b1;
                        phase_in  = PH_FAILED;
                        start_in  = item_ff.now_ms;
                        status_in = ST_LINK_FAIL;
                        if (cfail_ff != 16'hFFFF) begin
                           cfail_in = cfail_ff + 16'd1;
                        end
                     end
                  end
                  PH_CONNECTED: begin
                     if (!item_ff.link_up) begin
                        phase_in  = PH_FAILED;
                        start_in  = item_ff.now_ms;
                        status_in = ST_LINK_FAIL;
                     end
                  end
                  PH_FAILED: begin
                     if (elapsed >= retry_ff) begin
                        phase_in  = PH_CONNECTING;
                        start_in  = item_ff.now_ms;
                        status_in = ST_CONNECTING;
                        creq_in   = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            KIND_START: begin
               if (item_ff.has_credentials) begin
                  phase_in  = PH_CONNECTING;
                  start_in  = item_ff.now_ms;
                  status_in = ST_CONNECTING;
                  creq_in   = 1'b1;
               end else begin
                  status_in = ST_NO_CREDS;
               end
            end
            KIND_STOP: begin
               stopped_in = 1'b1;
               phase_in   = PH_IDLE;
               status_in  = ST_NO_CREDS;
               cfail_in   = 16'd0;
               dreq_in    = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_check && due) begin
         active_in = idx;
         busy_in   = 1'b1;
         dval_in   = 1'b1;
         dslot_in  = idx;
      end

      if (cmd.pd_fail) begin
         prod_in  = PROD_W'(base_ff[active_ff]) * PROD_W'(MS_PER_S);
         shift_in = (32'(fail_new) < SHIFT_MAX) ? 3'(fail_new) : 3'(SHIFT_MAX);
      end
      if (cmd.pd_cap) begin
         delay_in = (iv_ext > max_ff) ? max_ff : iv_ext;
      end
      if (cmd.pd_next) begin
         busy_in = 1'b0;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in                    = 1'b1;
         rsp_item_in.link_state          = phase_ff;
         rsp_item_in.status              = status_ff;
         rsp_item_in.connect_failures    = cfail_ff;
         rsp_item_in.connect_request     = creq_ff;
         rsp_item_in.disconnect_request  = dreq_ff;
         rsp_item_in.dispatch_valid      = dval_ff;
         rsp_item_in.dispatch_slot       = 3'(dslot_ff);
         rsp_item_in.next_delay_ms       = delay_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      idx_ff      <= idx_in;
      creq_ff     <= creq_in;
      dreq_ff     <= dreq_in;
      dval_ff     <= dval_in;
      dslot_ff    <= dslot_in;
      delay_ff    <= delay_in;
      prod_ff     <= prod_in;
      shift_ff    <= shift_in;
      rsp_item_ff <= rsp_item_in;
      if (cmd.exec && (item_ff.kind == KIND_SETUP) && setup_hit) begin
         base_ff[setup_idx] <= item_ff.slot_base_seconds;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= CONNECT_TIMEOUT_RESET;
         retry_ff     <= RETRY_INTERVAL_RESET;
         max_ff       <= MAX_BACKOFF_RESET;
         nslots_ff    <= ACTIVE_SLOTS_RESET;
         phase_ff     <= PH_IDLE;
         start_ff     <= 32'd0;
         status_ff    <= ST_INIT;
         cfail_ff     <= 16'd0;
         busy_ff      <= 1'b0;
         stopped_ff   <= 1'b0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            flags_ff[i] <= 3'd0;
            fail_ff[i]  <= 4'd0;
            next_ff[i]  <= 32'd0;
         end
      end else begin
         phase_ff     <= phase_in;
         start_ff     <= start_in;
         status_ff    <= status_in;
         cfail_ff     <= cfail_in;
         busy_ff      <= busy_in;
         stopped_ff   <= stopped_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_item.index)
               REG_CONNECT_TIMEOUT: timeout_ff <= csr_item.data;
               REG_RETRY_INTERVAL:  retry_ff   <= csr_item.data;
               REG_MAX_BACKOFF:     max_ff     <= csr_item.data;
               REG_ACTIVE_SLOTS:    nslots_ff  <= csr_item.data[3:0];
               default: begin
               end
            endcase
         end
         if (cmd.exec && (item_ff.kind == KIND_SETUP) && setup_hit) begin
            flags_ff[setup_idx] <= {item_ff.slot_auth_needed, item_ff.slot_configured,
                                    item_ff.slot_enabled};
         end
         if (cmd.clear_slot) begin
            fail_ff[idx] <= 4'd0;
            next_ff[idx] <= item_ff.now_ms;
         end
         if (cmd.pd_fail) begin
            fail_ff[active_ff] <= fail_new;
         end
         if (cmd.pd_next) begin
            next_ff[active_ff] <= item_ff.now_ms + delay_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: rtl/link_poll_scheduler_backoff.sv
// Top level of the link poll scheduler with per-slot exponential backoff.
// Depends on lpsb_pkg, lpsb_if, lpsb_controller and lpsb_datapath.
//
//   Channel    Direction  Carries
//   req_chan   in         one event item: tick, start, poll done, stop or slot setup
//   rsp_chan   out        one result item per event: link state, status and dispatch
//   csr_chan   in         register write: index and 32-bit data, always ready
//
// Start, stop, setup, unknown kinds, plain ticks and idle poll done items pass from
// accept through the execute state straight to the result. A tick that reaches the
// connected state adds a clearing sweep over the active slots; a tick that scans
// for a due slot adds a sweep that stops at the first due slot or the last active one.
// A poll done item that ends a dispatched poll runs the backoff arithmetic through
// the fail, cap and next states. Reset is synchronous; a stalled result is held in the
// output register and the next item is taken while it waits.
module link_poll_scheduler_backoff (
   input logic         clock,
   input logic         reset,
   lpsb_req_if.sink    req_chan,
   lpsb_rsp_if.source  rsp_chan,
   lpsb_csr_if.sink    csr_chan
);
   import lpsb_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_chan.ready = 1'b1;

   lpsb_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpsb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_item  (req_chan.payload),
      .csr_valid (csr_chan.valid),
      .csr_item  (csr_chan.payload),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_chan.payload)
   );

endmodule

FILE: rtl/lpsb_checker.sv
// Port-level checks on the result channel of the link poll scheduler.
// Depends on lpsb_pkg; attached to link_poll_scheduler_backoff by the bind below.
module lpsb_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input lpsb_pkg::rsp_payload_type rsp_payload
);
   import lpsb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Result item changed or dropped while stalled.");

   a_dispatch_connected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.dispatch_valid |-> rsp_payload.link_state == PH_CONNECTED)
      else $error("Slot dispatched while the link is not connected.");

   a_connect_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.connect_request |->
         rsp_payload.link_state == PH_CONNECTING && rsp_payload.status == ST_CONNECTING)
      else $error("Connect request without the connecting state.");

   a_delay_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.next_delay_ms != 32'd0 |->
         !rsp_payload.dispatch_valid && !rsp_payload.connect_request &&
         !rsp_payload.disconnect_request)
      else $error("Poll delay reported together with another event.");

   a_slot_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.dispatch_valid |-> rsp_payload.dispatch_slot == 3'd0)
      else $error("Dispatch slot set without a dispatch.");

endmodule

bind link_poll_scheduler_backoff lpsb_checker u_lpsb_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
